FILE: src/cfas_pkg.sv
// package: shared constants, types and helpers of the channel failure aging selector
`default_nettype none
package cfas_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int PTR_W        = $clog2(NUM_CHANNELS + 1);

   localparam int COUNT_W      = 8;
   localparam int TIME_W       = 32;
   localparam int ENTRY_W      = COUNT_W + TIME_W;
   localparam int OUT_IDX_W    = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX       = 8'hFF;
   localparam logic [TIME_W-1:0]  AGE_LIMIT_RESET = 32'd1800000;
   localparam logic [8:0]         CHAN_LIMIT      = 9'(NUM_CHANNELS);

   localparam logic CMD_SELECT = 1'b0;
   localparam logic CMD_RECORD = 1'b1;

   // memory port request from the engine
   typedef struct packed {
      logic               wr_en;
      logic [IDX_W-1:0]   wr_addr;
      logic [ENTRY_W-1:0] wr_data;
      logic               rd_en;
      logic [IDX_W-1:0]   rd_addr;
   } mem_req_type;

   // low bits of a channel index as shown on the result port
   function automatic logic [OUT_IDX_W-1:0] out_index(input logic [7:0] idx);
      return idx[OUT_IDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: src/cfas_ram.sv
// generic ram: one write port, one registered read port
`default_nettype none
module cfas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: src/cfas_engine.sv
// engine: command sequencer, aging, lowest-count search and record update
`default_nettype none
module cfas_engine import cfas_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 req_cmd,
   input  wire logic [TIME_W-1:0]    req_now_ms,
   input  wire logic [7:0]           req_channel_id,
   input  wire logic [TIME_W-1:0]    age_limit,
   input  wire logic [ENTRY_W-1:0]   rd_data,
   output mem_req_type               mem_req,
   output logic                      busy,
   output logic                      rsp_strobe,
   output logic [OUT_IDX_W-1:0]      rsp_channel_index,
   output logic [COUNT_W-1:0]        rsp_failure_count,
   output logic                      rsp_matched
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEL    = 2'd1;
   localparam logic [1:0] ST_REC_RD = 2'd2;
   localparam logic [1:0] ST_REC_WR = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [PTR_W-1:0]        ptr_ff, ptr_in;
   logic [TIME_W-1:0]       now_ff, now_in;
   logic [IDX_W-1:0]        id_ff, id_in;
   logic [COUNT_W-1:0]      lowest_ff, lowest_in;
   logic [IDX_W-1:0]        best_ff, best_in;
   logic [NUM_CHANNELS-1:0] valid_ff, valid_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic [OUT_IDX_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                    rsp_matched_ff, rsp_matched_in;

   logic [IDX_W-1:0]   chk_idx;
   logic [IDX_W-1:0]   ent_idx;
   logic [COUNT_W-1:0] ent_count;
   logic [TIME_W-1:0]  ent_time;
   logic [TIME_W-1:0]  elapsed;
   logic               aged;
   logic [COUNT_W-1:0] aged_count;
   logic [COUNT_W-1:0] bumped_count;

   // entry under check is the one read in the previous cycle
   assign chk_idx = IDX_W'(ptr_ff - 1'b1);
   assign ent_idx = (state_ff == ST_SEL) ? chk_idx : id_ff;

   // entries never written read as zero
   assign ent_count = valid_ff[ent_idx] ? rd_data[ENTRY_W-1:TIME_W] : '0;
   assign ent_time  = valid_ff[ent_idx] ? rd_data[TIME_W-1:0] : '0;

   assign elapsed      = now_ff - ent_time;
   assign aged         = (ent_count != '0) && (elapsed > age_limit);
   assign aged_count   = aged ? '0 : ent_count;
   assign bumped_count = (ent_count < COUNT_MAX) ? ent_count + 1'b1 : COUNT_MAX;

   always_comb begin
      state_in       = state_ff;
      ptr_in         = ptr_ff;
      now_in         = now_ff;
      id_in          = id_ff;
      lowest_in      = lowest_ff;
      best_in        = best_ff;
      valid_in       = valid_ff;
      rsp_strobe_in  = 1'b0;
      rsp_idx_in     = rsp_idx_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_matched_in = rsp_matched_ff;
      mem_req        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               now_in = req_now_ms;
               if (req_cmd == CMD_SELECT) begin
                  state_in  = ST_SEL;
                  ptr_in    = '0;
                  lowest_in = COUNT_MAX;
                  best_in   = '0;
               end else if ({1'b0, req_channel_id} < CHAN_LIMIT) begin
                  state_in = ST_REC_RD;
                  id_in    = req_channel_id[IDX_W-1:0];
               end else begin
                  rsp_strobe_in  = 1'b1;
                  rsp_idx_in     = '0;
                  rsp_count_in   = '0;
                  rsp_matched_in = 1'b0;
               end
            end
         end
         ST_SEL: begin
            mem_req.rd_en   = ptr_ff < PTR_W'(NUM_CHANNELS);
            mem_req.rd_addr = ptr_ff[IDX_W-1:0];
            ptr_in          = ptr_ff + 1'b1;
            if (ptr_ff != '0) begin
               if (aged) begin
                  mem_req.wr_en     = 1'b1;
                  mem_req.wr_addr   = chk_idx;
                  mem_req.wr_data   = {{COUNT_W{1'b0}}, ent_time};
                  valid_in[chk_idx] = 1'b1;
               end
               if (aged_count < lowest_ff) begin
                  lowest_in = aged_count;
                  best_in   = chk_idx;
               end
            end
            if (ptr_ff == PTR_W'(NUM_CHANNELS)) begin
               state_in       = ST_IDLE;
               rsp_strobe_in  = 1'b1;
               rsp_idx_in     = out_index(8'(best_in));
               rsp_count_in   = lowest_in;
               rsp_matched_in = 1'b1;
            end
         end
         ST_REC_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = id_ff;
            state_in        = ST_REC_WR;
         end
         ST_REC_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = id_ff;
            mem_req.wr_data = {bumped_count, now_ff};
            valid_in[id_ff] = 1'b1;
            state_in        = ST_IDLE;
            rsp_strobe_in   = 1'b1;
            rsp_idx_in      = out_index(8'(id_ff));
            rsp_count_in    = bumped_count;
            rsp_matched_in  = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      now_ff         <= now_in;
      id_ff          <= id_in;
      lowest_ff      <= lowest_in;
      best_ff        <= best_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_matched_ff <= rsp_matched_in;
   end

   assign busy              = state_ff != ST_IDLE;
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_channel_index = rsp_idx_ff;
   assign rsp_failure_count = rsp_count_ff;
   assign rsp_matched       = rsp_matched_ff;

endmodule
`default_nettype wire

FILE: src/channel_failure_aging_selector_unit.sv
// top level: channel failure aging selector with csr and channel table memory
`default_nettype none
// A transaction is taken at a rising edge with start high and busy low. Its
// result appears for exactly one cycle with rsp_strobe high; the receiver
// cannot stall, so it must take the result in that cycle. A select
// transaction walks the channel table one entry per cycle through the table
// memory's single read port, ages out stale counts on the way, holds busy
// high for the walk and strobes its registered result once the walk ends.
// A record transaction does one read-modify-write of the named entry, a
// read state then a write state, and strobes its registered result after
// the write; a record for a channel id outside the table strobes in the
// next cycle with matched low and leaves busy low. A new transaction may be
// started in the cycle its predecessor's result is strobed. The table resets
// to all zero at once through per-entry valid bits, so there is no clearing
// pass. The age limit register is written through csr_wr_en / csr_wr_data
// and should only be changed while the unit is idle.
module channel_failure_aging_selector_unit import cfas_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // command channel
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_cmd,
   input  wire logic [TIME_W-1:0]    req_now_ms,
   input  wire logic [7:0]           req_channel_id,
   // result channel
   output logic                      rsp_strobe,
   output logic [OUT_IDX_W-1:0]      rsp_channel_index,
   output logic [COUNT_W-1:0]        rsp_failure_count,
   output logic                      rsp_matched,
   // age limit register
   input  wire logic                 csr_wr_en,
   input  wire logic [TIME_W-1:0]    csr_wr_data
);

   logic [TIME_W-1:0]  age_limit_ff;
   logic [TIME_W-1:0]  age_limit_in;
   mem_req_type        mem_req;
   logic [ENTRY_W-1:0] rd_data;
   logic               engine_busy;

   // age limit register, write only
   assign age_limit_in = csr_wr_en ? csr_wr_data : age_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         age_limit_ff <= AGE_LIMIT_RESET;
      end else begin
         age_limit_ff <= age_limit_in;
      end
   end

   // channel table: {failure count, last failure time} per channel
   cfas_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(NUM_CHANNELS)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

   // sequencer: select walks the table, record updates one entry
   cfas_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .start             (start & ~engine_busy),
      .req_cmd           (req_cmd),
      .req_now_ms        (req_now_ms),
      .req_channel_id    (req_channel_id),
      .age_limit         (age_limit_ff),
      .rd_data           (rd_data),
      .mem_req           (mem_req),
      .busy              (engine_busy),
      .rsp_strobe        (rsp_strobe),
      .rsp_channel_index (rsp_channel_index),
      .rsp_failure_count (rsp_failure_count),
      .rsp_matched       (rsp_matched)
   );

   assign busy = engine_busy;

endmodule
`default_nettype wire

FILE: src/cfas_checker.sv
// checker: port-level properties of the selector, bound to the top level
`default_nettype none
module cfas_checker import cfas_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire logic                 busy,
   input wire logic                 req_cmd,
   input wire logic [7:0]           req_channel_id,
   input wire logic                 rsp_strobe,
   input wire logic [OUT_IDX_W-1:0] rsp_channel_index,
   input wire logic [COUNT_W-1:0]   rsp_failure_count,
   input wire logic                 rsp_matched
);

   logic in_range;
   assign in_range = {1'b0, req_channel_id} < CHAN_LIMIT;

   // after reset the unit is idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_strobe)
      else $error("unit not idle after reset");

   // select or known record holds busy in the next cycle
   a_busy_on_work: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd == CMD_SELECT || in_range) |=> busy)
      else $error("busy not raised for accepted transaction");

   // unknown channel record answers at once with a cleared result
   a_unknown_record: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_cmd == CMD_RECORD && !in_range |=>
         rsp_strobe && !rsp_matched && !busy)
      else $error("unknown channel record mishandled");

   // known channel record strobes a matched result with a nonzero count
   a_record_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_cmd == CMD_RECORD && in_range |->
         ##3 (rsp_strobe && rsp_matched && rsp_failure_count != '0))
      else $error("record result missing or wrong");

   // an unmatched result carries zeros
   a_unmatched_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_matched |-> rsp_channel_index == '0 && rsp_failure_count == '0)
      else $error("unmatched result not zero");

endmodule

bind channel_failure_aging_selector_unit cfas_checker u_cfas_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_cmd           (req_cmd),
   .req_channel_id    (req_channel_id),
   .rsp_strobe        (rsp_strobe),
   .rsp_channel_index (rsp_channel_index),
   .rsp_failure_count (rsp_failure_count),
   .rsp_matched       (rsp_matched)
);
`default_nettype wire
